>>> design/vt1_pkg.sv
// Shared types, register map codes and the addressable latch decode
// for the timer 1 / port latch interface adapter. No dependencies.
package vt1_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // Standard 6522 register map.
    localparam logic [3:0] REG_ORB   = 4'd0;
    localparam logic [3:0] REG_ORA   = 4'd1;
    localparam logic [3:0] REG_DDRB  = 4'd2;
    localparam logic [3:0] REG_DDRA  = 4'd3;
    localparam logic [3:0] REG_T1CL  = 4'd4;
    localparam logic [3:0] REG_T1CH  = 4'd5;
    localparam logic [3:0] REG_T1LL  = 4'd6;
    localparam logic [3:0] REG_T1LH  = 4'd7;
    localparam logic [3:0] REG_T2CL  = 4'd8;
    localparam logic [3:0] REG_T2CH  = 4'd9;
    localparam logic [3:0] REG_SR    = 4'd10;
    localparam logic [3:0] REG_ACR   = 4'd11;
    localparam logic [3:0] REG_PCR   = 4'd12;
    localparam logic [3:0] REG_IFR   = 4'd13;
    localparam logic [3:0] REG_IER   = 4'd14;
    localparam logic [3:0] REG_ORA_NH = 4'd15;

    localparam logic [7:0] KEY_PROBE_DDR = 8'h7f;
    localparam logic [7:0] T1_IRQ_BITS   = 8'hc0;
    localparam int         T1_FLAG_BIT   = 6;
    localparam int         FREE_RUN_BIT  = 6;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       probed_key_down;
    } step_t;

    typedef struct packed {
        logic [7:0] sound_byte;
        logic       sound_strobe;
        logic [7:0] latch_bits;
        logic       irq;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic [7:0] latch_bits;
        logic       strobe;
    } latch_upd_t;

    // One addressable latch command: sel[2:0] picks the bit, sel[3] the level.
    // Bits 3, 4 and 5 follow the level; the others are active low. Bit 0
    // going low while set pushes the port A byte to the sound chip.
    function automatic latch_upd_t vt1_latch_cmd(input logic [7:0] latch,
                                                 input logic [3:0] sel);
        latch_upd_t r;
        logic       on;
        r.latch_bits = latch;
        r.strobe     = 1'b0;
        if (sel[2:0] == 3'd0) begin
            on       = !sel[3];
            r.strobe = sel[3] && latch[0];
        end
        else if (sel[2:0] == 3'd3 || sel[2:0] == 3'd4 || sel[2:0] == 3'd5) begin
            on = sel[3];
        end
        else begin
            on = !sel[3];
        end
        r.latch_bits[sel[2:0]] = on;
        return r;
    endfunction

endpackage

>>> design/vt1_core.sv
// Register file, timer 1 and port latch state of the interface adapter.
// Applies one step per cycle when enabled. Depends on vt1_pkg.
module vt1_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  vt1_pkg::step_t   step,
    output vt1_pkg::result_t result
);
    import vt1_pkg::*;

    logic [7:0]  dir_a_reg, dir_a_next;
    logic [7:0]  dir_b_reg, dir_b_next;
    logic [7:0]  out_a_reg, out_a_next;
    logic [7:0]  out_b_reg, out_b_next;
    logic [7:0]  in_a_reg, in_a_next;
    logic [6:0]  irq_enable_reg, irq_enable_next;
    logic [7:0]  irq_flags_reg, irq_flags_next;
    logic [7:0]  periph_ctrl_reg, periph_ctrl_next;
    logic [7:0]  aux_ctrl_reg, aux_ctrl_next;
    logic [15:0] t1_reload_reg, t1_reload_next;
    logic [15:0] t1_value_reg, t1_value_next;
    logic        t1_active_reg, t1_active_next;
    logic [7:0]  latch_bits_reg, latch_bits_next;

    logic [15:0] t1_dec;
    logic [7:0]  flags_tmp;
    logic [7:0]  rd;
    logic        strobe;
    latch_upd_t  upd;

    always_comb
    begin
        dir_a_next       = dir_a_reg;
        dir_b_next       = dir_b_reg;
        out_a_next       = out_a_reg;
        out_b_next       = out_b_reg;
        in_a_next        = in_a_reg;
        irq_enable_next  = irq_enable_reg;
        irq_flags_next   = irq_flags_reg;
        periph_ctrl_next = periph_ctrl_reg;
        aux_ctrl_next    = aux_ctrl_reg;
        t1_reload_next   = t1_reload_reg;
        t1_value_next    = t1_value_reg;
        t1_active_next   = t1_active_reg;
        latch_bits_next  = latch_bits_reg;
        t1_dec           = t1_value_reg - 16'd1;
        flags_tmp        = irq_flags_reg;
        rd               = 8'd0;
        strobe           = 1'b0;
        upd              = vt1_latch_cmd(latch_bits_reg, out_b_reg[3:0] & dir_b_reg[3:0]);

        case (step.mode)
            MODE_TICK:
            begin
                if (t1_active_reg)
                begin
                    t1_value_next = t1_dec;
                    if (t1_dec == 16'd0)
                    begin
                        if (irq_enable_reg[T1_FLAG_BIT])
                        begin
                            irq_flags_next = irq_flags_reg | T1_IRQ_BITS;
                        end
                        if (aux_ctrl_reg[FREE_RUN_BIT])
                        begin
                            t1_value_next = t1_reload_reg;
                            if (dir_b_reg[7])
                            begin
                                out_b_next = out_b_reg ^ 8'h80;
                                upd = vt1_latch_cmd(latch_bits_reg,
                                                    out_b_next[3:0] & dir_b_reg[3:0]);
                                latch_bits_next = upd.latch_bits;
                                strobe          = upd.strobe;
                            end
                        end
                        else
                        begin
                            t1_active_next = 1'b0;
                        end
                    end
                end
            end
            MODE_WRITE:
            begin
                case (step.reg_addr)
                    REG_ORB:
                    begin
                        out_b_next = step.write_data;
                        upd = vt1_latch_cmd(latch_bits_reg,
                                            step.write_data[3:0] & dir_b_reg[3:0]);
                        latch_bits_next = upd.latch_bits;
                        strobe          = upd.strobe;
                    end
                    REG_ORA, REG_ORA_NH:
                    begin
                        out_a_next = dir_a_reg & step.write_data;
                        if (dir_a_reg == KEY_PROBE_DDR)
                        begin
                            in_a_next = step.probed_key_down ?
                                        {1'b1, out_a_next[6:0]} : 8'd0;
                        end
                    end
                    REG_DDRB: dir_b_next = step.write_data;
                    REG_DDRA: dir_a_next = step.write_data;
                    REG_T1CL, REG_T1LL: t1_reload_next = {t1_reload_reg[15:8], step.write_data};
                    REG_T1LH: t1_reload_next = {step.write_data, t1_reload_reg[7:0]};
                    REG_T1CH:
                    begin
                        t1_reload_next = {step.write_data, t1_reload_reg[7:0]};
                        t1_value_next  = t1_reload_next;
                        t1_active_next = 1'b1;
                        flags_tmp      = irq_flags_reg;
                        flags_tmp[T1_FLAG_BIT] = 1'b0;
                        irq_flags_next = (flags_tmp[6:0] == 7'd0) ? 8'd0 : flags_tmp;
                    end
                    REG_ACR: aux_ctrl_next    = step.write_data;
                    REG_PCR: periph_ctrl_next = step.write_data;
                    REG_IFR:
                    begin
                        if (!step.write_data[7])
                        begin
                            flags_tmp      = irq_flags_reg & ~step.write_data;
                            irq_flags_next = (flags_tmp[6:0] == 7'd0) ? 8'd0 : flags_tmp;
                        end
                    end
                    REG_IER:
                    begin
                        if (step.write_data[7])
                        begin
                            irq_enable_next = irq_enable_reg | step.write_data[6:0];
                        end
                        else
                        begin
                            irq_enable_next = irq_enable_reg & ~step.write_data[6:0];
                        end
                    end
                    default: ;
                endcase
            end
            MODE_READ:
            begin
                case (step.reg_addr)
                    REG_ORA, REG_ORA_NH: rd = in_a_reg;
                    REG_DDRB: rd = dir_b_reg;
                    REG_DDRA: rd = dir_a_reg;
                    REG_T1CL: rd = t1_value_reg[7:0];
                    REG_T1CH: rd = t1_value_reg[15:8];
                    REG_T1LL: rd = t1_reload_reg[7:0];
                    REG_T1LH: rd = t1_reload_reg[15:8];
                    REG_ACR:  rd = aux_ctrl_reg;
                    REG_PCR:  rd = periph_ctrl_reg;
                    REG_IFR:  rd = irq_flags_reg;
                    REG_IER:  rd = {1'b1, irq_enable_reg};
                    default:  rd = 8'd0;
                endcase
            end
            default: ;
        endcase

        // A sound push clears the keyboard input byte.
        if (strobe)
        begin
            in_a_next = 8'd0;
        end

        result.read_data    = rd;
        result.irq          = irq_flags_next[7];
        result.latch_bits   = latch_bits_next;
        result.sound_strobe = strobe;
        result.sound_byte   = strobe ? out_a_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_a_reg       <= '0;
            dir_b_reg       <= '0;
            out_a_reg       <= '0;
            out_b_reg       <= '0;
            in_a_reg        <= '0;
            irq_enable_reg  <= '0;
            irq_flags_reg   <= '0;
            periph_ctrl_reg <= '0;
            aux_ctrl_reg    <= '0;
            t1_reload_reg   <= '0;
            t1_value_reg    <= '0;
            t1_active_reg   <= 1'b0;
            latch_bits_reg  <= '0;
        end
        else if (step_en)
        begin
            dir_a_reg       <= dir_a_next;
            dir_b_reg       <= dir_b_next;
            out_a_reg       <= out_a_next;
            out_b_reg       <= out_b_next;
            in_a_reg        <= in_a_next;
            irq_enable_reg  <= irq_enable_next;
            irq_flags_reg   <= irq_flags_next;
            periph_ctrl_reg <= periph_ctrl_next;
            aux_ctrl_reg    <= aux_ctrl_next;
            t1_reload_reg   <= t1_reload_next;
            t1_value_reg    <= t1_value_next;
            t1_active_reg   <= t1_active_next;
            latch_bits_reg  <= latch_bits_next;
        end
    end

endmodule

>>> design/via_timer1_irq_and_port_latch.sv
// Top level of the timer 1 / port latch interface adapter: input register,
// step core and result register. Depends on vt1_pkg and vt1_core.
// Path: an accepted transfer waits in the input register until the result
// register is free or being drained; the core then steps it and its result
// is registered in the result register.
// Throughput: one transfer per cycle, bounded only by the downstream tready.
// Reset: rst_n is asynchronous and active low; it clears all core state,
// both stage valid bits, and leaves the sound enable latch bit off.
module via_timer1_irq_and_port_latch (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [1:0] mode, [5:2] reg_addr, [13:6] write_data, [14] probed_key_down
    input  logic [vt1_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] read_data, [8] irq, [9] sound_enabled, [10] read_speech,
    // [11] write_speech, [12] key_autoscan, [13] scroll_c0, [14] scroll_c1,
    // [15] caps_led, [16] shift_led, [17] sound_strobe, [25:18] sound_byte
    output logic [vt1_pkg::OUT_W-1:0]  m_tdata
);
    import vt1_pkg::*;

    // Input register: holds one accepted transfer until the core steps it.
    logic    in_valid_reg;
    step_t   in_step_reg;
    // Result register: holds one finished result until it is taken.
    logic    out_valid_reg;
    result_t out_res_reg;

    result_t core_res;
    logic    advance;

    // The core steps whenever the result register is free or being drained,
    // so a new transfer can enter every cycle even with a result pending.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vt1_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .step    (in_step_reg),
        .result  (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_step_reg.mode            <= mode_t'(s_tdata[1:0]);
            in_step_reg.reg_addr        <= s_tdata[5:2];
            in_step_reg.write_data      <= s_tdata[13:6];
            in_step_reg.probed_key_down <= s_tdata[14];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_res_reg.sound_byte,
                       out_res_reg.sound_strobe,
                       out_res_reg.latch_bits,
                       out_res_reg.irq,
                       out_res_reg.read_data};

    // A held transfer is never dropped while the core is blocked.
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input transfer lost while stalled");

    // Every core step leaves a result in the output register.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("core step produced no result");

    // The sound byte is only nonzero alongside its strobe.
    a_sound_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_res_reg.sound_strobe |-> out_res_reg.sound_byte == 8'd0)
        else $error("sound byte without strobe");

endmodule

>>> sim/via_timer1_irq_and_port_latch_test.sv
// Self-checking testbench for the timer 1 / port latch interface adapter.
// Depends on vt1_pkg and via_timer1_irq_and_port_latch; predicts every result
// with its own model of the adapter and checks the output stream against it.
module via_timer1_irq_and_port_latch_test;

    import vt1_pkg::*;

    // Clock, reset and the two stream groups. Every input starts at a known value.
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] mode, [5:2] reg_addr, [13:6] write_data, [14] probed_key_down
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] read_data, [8] irq, [16:9] latch bits from sound_enabled up to
    // shift_led, [17] sound_strobe, [25:18] sound_byte
    logic [OUT_W-1:0]     m_tdata;

    via_timer1_irq_and_port_latch i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bus accesses waiting to be offered, and the results the adapter owes us.
    step_t   bus_accesses[$];
    result_t due_results[$];

    // Our own copy of the adapter state, updated once per accepted transfer.
    logic [7:0]  ddr_a, ddr_b, ora_q, orb_q, pa_in;
    logic [6:0]  ier_q;
    logic [7:0]  ifr_q, pcr_q, acr_q;
    logic [15:0] t1_latch, t1_count;
    logic        t1_running;
    logic [7:0]  addr_latch;
    logic        push_now;
    logic [7:0]  pushed_byte;

    int accesses_queued  = 0;
    int accesses_sent    = 0;
    int results_checked  = 0;
    int mismatch_count   = 0;
    int sound_pushes     = 0;
    int t1_timeouts      = 0;
    int reads_done       = 0;

    // Driver and monitor bookkeeping.
    step_t   offered_step;
    int      send_gap       = 0;
    int      send_calm      = 0;
    int      recv_stall     = 0;
    int      recv_calm      = 0;
    logic    long_hold_done = 1'b0;
    result_t got_result, want_result;
    logic [5:0] got_pad;

    initial
    begin
        ddr_a = '0; ddr_b = '0; ora_q = '0; orb_q = '0; pa_in = '0;
        ier_q = '0; ifr_q = '0; pcr_q = '0; acr_q = '0;
        t1_latch = '0; t1_count = '0; t1_running = 1'b0;
        addr_latch = '0; push_now = 1'b0; pushed_byte = '0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Port B selects one bit of the addressable latch. The low three bits of
    // ORB (masked by DDRB) pick the bit and ORB bit 3 gives the level. Bits
    // 3 to 5 follow the level, the rest are active low. Releasing the sound
    // enable while it was on pushes the port A byte to the sound chip.
    function automatic void apply_latch_cmd();
        logic [3:0] sel;
        logic [2:0] pos;
        logic       lvl;
        logic       on;
        sel = orb_q[3:0] & ddr_b[3:0];
        pos = sel[2:0];
        lvl = sel[3];
        if (pos == 3'd0)
        begin
            if (lvl)
            begin
                if (addr_latch[0])
                begin
                    push_now    = 1'b1;
                    pushed_byte = ora_q;
                    pa_in       = 8'h00;
                    sound_pushes++;
                end
                on = 1'b0;
            end
            else
            begin
                on = 1'b1;
            end
        end
        else if (pos == 3'd3 || pos == 3'd4 || pos == 3'd5)
        begin
            on = lvl;
        end
        else
        begin
            on = !lvl;
        end
        addr_latch[pos] = on;
    endfunction

    // The timer flag only shows up in IFR when IER enables it.
    function automatic void raise_t1_flag();
        if (ier_q[T1_FLAG_BIT])
            ifr_q = ifr_q | T1_IRQ_BITS;
    endfunction

    // The master bit drops once no individual flag is left.
    function automatic void tidy_ifr();
        if (ifr_q[6:0] == 7'd0)
            ifr_q = 8'h00;
    endfunction

    function automatic result_t compute_via_result(step_t acc);
        result_t    r;
        logic [7:0] rd;
        logic [7:0] d;
        rd          = 8'h00;
        d           = acc.write_data;
        push_now    = 1'b0;
        pushed_byte = 8'h00;
        case (acc.mode)
            MODE_TICK:
            begin
                if (t1_running)
                begin
                    t1_count = t1_count - 16'd1;
                    if (t1_count == 16'd0)
                    begin
                        t1_timeouts++;
                        if (acr_q[FREE_RUN_BIT])
                        begin
                            // Free-run flips an output PB7, re-issuing the latch cmd.
                            if (ddr_b[7])
                            begin
                                orb_q[7] = ~orb_q[7];
                                apply_latch_cmd();
                            end
                            raise_t1_flag();
                            t1_count = t1_latch;
                        end
                        else
                        begin
                            t1_running = 1'b0;
                            raise_t1_flag();
                        end
                    end
                end
            end
            MODE_WRITE:
            begin
                case (acc.reg_addr)
                    REG_ORB:
                    begin
                        orb_q = d;
                        apply_latch_cmd();
                    end
                    REG_ORA, REG_ORA_NH:
                    begin
                        ora_q = ddr_a & d;
                        if (ddr_a == KEY_PROBE_DDR)
                            pa_in = acc.probed_key_down ? {1'b1, ora_q[6:0]} : 8'h00;
                    end
                    REG_DDRB: ddr_b = d;
                    REG_DDRA: ddr_a = d;
                    REG_T1CL, REG_T1LL: t1_latch[7:0] = d;
                    REG_T1LH: t1_latch[15:8] = d;
                    REG_T1CH:
                    begin
                        t1_latch[15:8]     = d;
                        t1_count           = t1_latch;
                        ifr_q[T1_FLAG_BIT] = 1'b0;
                        tidy_ifr();
                        t1_running         = 1'b1;
                    end
                    REG_ACR: acr_q = d;
                    REG_PCR: pcr_q = d;
                    REG_IFR:
                    begin
                        if (!d[7])
                        begin
                            ifr_q = ifr_q & ~d;
                            tidy_ifr();
                        end
                    end
                    REG_IER:
                    begin
                        if (d[7])
                            ier_q = ier_q | d[6:0];
                        else
                            ier_q = ier_q & ~d[6:0];
                    end
                    default: ;
                endcase
            end
            MODE_READ:
            begin
                reads_done++;
                case (acc.reg_addr)
                    REG_ORA, REG_ORA_NH: rd = pa_in;
                    REG_DDRB: rd = ddr_b;
                    REG_DDRA: rd = ddr_a;
                    REG_T1CL: rd = t1_count[7:0];
                    REG_T1CH: rd = t1_count[15:8];
                    REG_T1LL: rd = t1_latch[7:0];
                    REG_T1LH: rd = t1_latch[15:8];
                    REG_ACR:  rd = acr_q;
                    REG_PCR:  rd = pcr_q;
                    REG_IFR:  rd = ifr_q;
                    REG_IER:  rd = {1'b1, ier_q};
                    default:  rd = 8'h00;
                endcase
            end
            default: ;
        endcase
        r.read_data    = rd;
        r.irq          = ifr_q[7];
        r.latch_bits   = addr_latch;
        r.sound_strobe = push_now;
        r.sound_byte   = push_now ? pushed_byte : 8'h00;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle pattern shared by both sides: mostly none or short, a few long,
    // and now and then a calm stretch of back-to-back transfers.
    // ------------------------------------------------------------------
    function automatic int idle_span(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued accesses, predicts each one as it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                due_results.push_back(compute_via_result(offered_step));
                accesses_sent++;
                send_gap = idle_span(send_calm);
            end
            // A new decision is taken only when nothing is pending on the bus or the
            // pending access is being taken, so an offered access stays until accepted.
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (bus_accesses.size() != 0)
                begin
                    offered_step = bus_accesses.pop_front();
                    s_tdata  <= {1'b0, offered_step.probed_key_down, offered_step.write_data,
                                 offered_step.reg_addr, offered_step.mode};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction and
    // throttles tready. Once, well into the run, it holds off for a long
    // stretch so that the pipeline fills and back-pressures the sender.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_result = result_t'(m_tdata[25:0]);
                got_pad    = m_tdata[31:26];
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result transfer %0d arrived with nothing expected: %h",
                                 results_checked, m_tdata);
                end
                else
                begin
                    want_result = due_results.pop_front();
                    if (got_result.read_data    !== want_result.read_data    ||
                        got_result.irq          !== want_result.irq          ||
                        got_result.latch_bits   !== want_result.latch_bits   ||
                        got_result.sound_strobe !== want_result.sound_strobe ||
                        got_result.sound_byte   !== want_result.sound_byte   ||
                        got_pad                 !== 6'd0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d mismatch: expected rd=%h irq=%b latch=%b ",
                                      "strobe=%b byte=%h, got rd=%h irq=%b latch=%b ",
                                      "strobe=%b byte=%h pad=%h"},
                                     results_checked,
                                     want_result.read_data, want_result.irq,
                                     want_result.latch_bits, want_result.sound_strobe,
                                     want_result.sound_byte,
                                     got_result.read_data, got_result.irq,
                                     got_result.latch_bits, got_result.sound_strobe,
                                     got_result.sound_byte, got_pad);
                    end
                end
                results_checked++;
            end

            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && results_checked >= 300)
            begin
                long_hold_done = 1'b1;
                recv_stall     = 249;
                m_tready      <= 1'b0;
            end
            else
            begin
                recv_stall = idle_span(recv_calm);
                if (recv_stall > 0)
                begin
                    recv_stall--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic queue_access(mode_t m, logic [3:0] a, logic [7:0] d, logic k);
        step_t acc;
        acc.mode            = m;
        acc.reg_addr        = a;
        acc.write_data      = d;
        acc.probed_key_down = k;
        bus_accesses.push_back(acc);
        accesses_queued++;
    endtask

    // Timer ticks carry random, ignored address and data bits.
    task automatic queue_tick();
        queue_access(MODE_TICK, 4'($urandom_range(0, 15)), rand_byte(), rand_bit());
    endtask

    task automatic queue_read(logic [3:0] a);
        queue_access(MODE_READ, a, rand_byte(), rand_bit());
    endtask

    // Program timer 1 with a short count, then tick it toward time-out.
    task automatic timer_sequence();
        int         n;
        logic [7:0] d;
        d = ($urandom_range(0, 9) == 0) ? rand_byte() : 8'($urandom_range(1, 6));
        queue_access(MODE_WRITE, rand_bit() ? REG_T1LL : REG_T1CL, d, rand_bit());
        if (rand_bit())
        begin
            d = rand_byte();
            if ($urandom_range(0, 3) != 0)
                d[7:6] = 2'b11;
            queue_access(MODE_WRITE, REG_IER, d, rand_bit());
        end
        if (rand_bit())
            queue_access(MODE_WRITE, REG_ACR, rand_byte(), rand_bit());
        if ($urandom_range(0, 3) == 0)
        begin
            d = rand_byte();
            d[7] = ($urandom_range(0, 3) != 0);
            queue_access(MODE_WRITE, REG_DDRB, d, rand_bit());
        end
        d = ($urandom_range(0, 6) == 0) ? rand_byte() : 8'h00;
        queue_access(MODE_WRITE, REG_T1CH, d, rand_bit());
        n = $urandom_range(1, 14);
        repeat (n)
        begin
            if ($urandom_range(0, 6) == 0)
                queue_read(($urandom_range(0, 2) == 0) ? REG_IFR :
                           (rand_bit() ? REG_T1CL : REG_T1CH));
            else
                queue_tick();
        end
        if (rand_bit())
        begin
            d = rand_byte();
            d[7] = ($urandom_range(0, 4) == 0);
            queue_access(MODE_WRITE, REG_IFR, d, rand_bit());
        end
        if ($urandom_range(0, 2) == 0)
            queue_read(REG_IFR);
    endtask

    // Walk the addressable latch, now and then with a sound byte pushed.
    task automatic latch_sequence();
        int n;
        queue_access(MODE_WRITE, REG_DDRB,
                     ($urandom_range(0, 9) < 7) ? 8'hff : rand_byte(), rand_bit());
        if ($urandom_range(0, 9) < 3)
        begin
            queue_access(MODE_WRITE, REG_DDRA, 8'hff, rand_bit());
            queue_access(MODE_WRITE, rand_bit() ? REG_ORA : REG_ORA_NH, rand_byte(), rand_bit());
        end
        n = $urandom_range(2, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                queue_access(MODE_WRITE, REG_ORB, {rand_byte() & 8'hf0}, rand_bit());
                queue_access(MODE_WRITE, REG_ORB, {rand_byte() & 8'hf0} | 8'h08, rand_bit());
            end
            else
            begin
                queue_access(MODE_WRITE, REG_ORB, rand_byte(), rand_bit());
            end
        end
        if ($urandom_range(0, 3) == 0)
            queue_read(REG_ORB);
    endtask

    // Keyboard probe through port A, mostly with the probe direction set.
    task automatic key_sequence();
        int n;
        queue_access(MODE_WRITE, REG_DDRA,
                     ($urandom_range(0, 4) != 0) ? KEY_PROBE_DDR : rand_byte(), rand_bit());
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            queue_access(MODE_WRITE, rand_bit() ? REG_ORA : REG_ORA_NH, rand_byte(), rand_bit());
            queue_read(rand_bit() ? REG_ORA : REG_ORA_NH);
        end
    endtask

    task automatic random_phase(int target);
        int pick;
        int n;
        while (accesses_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                timer_sequence();
            end
            else if (pick < 60)
            begin
                latch_sequence();
            end
            else if (pick < 75)
            begin
                key_sequence();
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 4);
                repeat (n) queue_read(4'($urandom_range(0, 15)));
            end
            else
            begin
                // Noise: any mode, any register, any data, including no-ops.
                n = $urandom_range(1, 3);
                repeat (n)
                    queue_access(mode_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                 rand_byte(), rand_bit());
            end
        end
    endtask

    // Wait, sampling away from the active edge, until every queued access has
    // been taken and every predicted result has been seen.
    task automatic wait_drained();
        @(negedge clk);
        while (bus_accesses.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: reset values, every mode, the latch strobe with and
        // without sound enabled, the key probe, a free-run time-out with PB7
        // toggle, IFR/IER set and clear rules and the ignored Timer 2 / SR.
        queue_read(REG_IER);
        queue_access(MODE_NOP, REG_ORA_NH, 8'hff, 1'b1);
        queue_access(MODE_WRITE, REG_DDRB, 8'hff, 1'b0);
        queue_access(MODE_WRITE, REG_ORB, 8'h00, 1'b0);
        queue_access(MODE_WRITE, REG_DDRA, 8'hff, 1'b0);
        queue_access(MODE_WRITE, REG_ORA, 8'ha5, 1'b0);
        queue_access(MODE_WRITE, REG_ORB, 8'h08, 1'b0);
        queue_access(MODE_WRITE, REG_ORB, 8'h08, 1'b0);
        queue_access(MODE_WRITE, REG_DDRA, KEY_PROBE_DDR, 1'b0);
        queue_access(MODE_WRITE, REG_ORA, 8'hff, 1'b1);
        queue_read(REG_ORA_NH);
        queue_access(MODE_WRITE, REG_ORA_NH, 8'h12, 1'b0);
        queue_access(MODE_WRITE, REG_IER, 8'hc0, 1'b0);
        queue_access(MODE_WRITE, REG_ACR, 8'h40, 1'b0);
        queue_access(MODE_WRITE, REG_T1LL, 8'h02, 1'b0);
        queue_access(MODE_WRITE, REG_T1CH, 8'h00, 1'b0);
        queue_tick();
        queue_tick();
        queue_read(REG_IFR);
        queue_access(MODE_WRITE, REG_IFR, 8'h80, 1'b0);
        queue_access(MODE_WRITE, REG_IFR, 8'h40, 1'b0);
        queue_access(MODE_WRITE, REG_T2CL, 8'hff, 1'b1);
        queue_read(REG_SR);
        queue_access(MODE_WRITE, REG_IER, 8'h7f, 1'b0);
        queue_access(MODE_WRITE, REG_PCR, 8'hff, 1'b0);
        queue_read(REG_PCR);
        queue_access(MODE_WRITE, REG_T1LH, 8'hff, 1'b0);
        queue_read(REG_T1LH);
        wait_drained();

        // Random part in two halves; the sender stays quiet between them
        // until every outstanding result has come back.
        random_phase(accesses_queued + 475);
        wait_drained();
        random_phase(accesses_queued + 475);
        wait_drained();

        // Two pipeline stages: spare cycles here catch any stray result.
        repeat (8) @(posedge clk);

        $display("covered %0d bus transfers (%0d reads), %0d results checked",
                 accesses_sent, reads_done, results_checked);
        $display("%0d sound byte pushes and %0d timer 1 time-outs predicted",
                 sound_pushes, t1_timeouts);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("via_timer1_irq_and_port_latch regression: pass");
        else
            $display("via_timer1_irq_and_port_latch regression: fail");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #5000000;
        $display("timeout after %0d transfers sent, %0d results checked",
                 accesses_sent, results_checked);
        $display("via_timer1_irq_and_port_latch regression: fail");
        $finish;
    end

endmodule

>>> via_timer1_irq_and_port_latch.f
design/vt1_pkg.sv
design/vt1_core.sv
design/via_timer1_irq_and_port_latch.sv
sim/via_timer1_irq_and_port_latch_test.sv
